@@ sv/mips32_subset_execute_macros.svh @@
// Assertion macros for the execute block.
`ifndef MIPS32_SUBSET_EXECUTE_MACROS_SVH
`define MIPS32_SUBSET_EXECUTE_MACROS_SVH
`ifndef SYNTHESIS
`define MSE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mse: same-cycle check failed");
`define MSE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mse: next-cycle check failed");
`else
`define MSE_ASSERT_IMP(lbl, ante, cons)
`define MSE_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ sv/mse_pkg.sv @@
`default_nettype none
package mse_pkg;
  localparam int unsigned DMEM_WORDS_DEF = 1024;
  localparam logic [31:0] TEXT_BASE_RST = 32'h0040_0000;
  localparam logic [31:0] CODE_SIZE_RST = 32'h0000_0000;

  localparam logic KIND_EXEC    = 1'b0;
  localparam logic KIND_PRELOAD = 1'b1;

  localparam logic REG_TEXT_BASE = 1'b0;
  localparam logic REG_CODE_SIZE = 1'b1;

  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0a;
  localparam logic [5:0] OP_SLTIU   = 6'h0b;
  localparam logic [5:0] OP_ANDI    = 6'h0c;
  localparam logic [5:0] OP_ORI     = 6'h0d;
  localparam logic [5:0] OP_LUI     = 6'h0f;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_LBU     = 6'h24;
  localparam logic [5:0] OP_LHU     = 6'h25;
  localparam logic [5:0] OP_SW      = 6'h2b;

  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_SRL  = 6'h02;
  localparam logic [5:0] FN_JR   = 6'h08;
  localparam logic [5:0] FN_ADD  = 6'h20;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_SUB  = 6'h22;
  localparam logic [5:0] FN_SUBU = 6'h23;
  localparam logic [5:0] FN_AND  = 6'h24;
  localparam logic [5:0] FN_OR   = 6'h25;
  localparam logic [5:0] FN_NOR  = 6'h27;
  localparam logic [5:0] FN_SLT  = 6'h2a;
  localparam logic [5:0] FN_SLTU = 6'h2b;

  typedef struct packed {
    logic        we;
    logic [4:0]  idx;
    logic [31:0] val;
  } wb_t;
endpackage
`default_nettype wire

@@ sv/mse_alu.sv @@
`default_nettype none
module mse_alu (
  input  wire logic [31:0] w,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  input  wire logic [31:0] pc,
  input  wire logic [31:0] dword,
  input  wire logic [1:0]  ea_lo,
  output mse_pkg::wb_t     wb
);
  logic [31:0] simm;
  logic [31:0] zimm;
  logic [31:0] byte_sh;
  logic [31:0] half_sh;

  assign simm    = {{16{w[15]}}, w[15:0]};
  assign zimm    = {16'h0000, w[15:0]};
  assign byte_sh = dword >> {ea_lo, 3'b000};
  assign half_sh = dword >> {ea_lo[1], 4'b0000};

  always_comb begin
    wb = '0;
    unique case (w[31:26])
      mse_pkg::OP_SPECIAL: begin
        wb.we  = 1'b1;
        wb.idx = w[15:11];
        case (w[5:0])
          mse_pkg::FN_ADD, mse_pkg::FN_ADDU: wb.val = a + b;
          mse_pkg::FN_SUB, mse_pkg::FN_SUBU: wb.val = a - b;
          mse_pkg::FN_AND:  wb.val = a & b;
          mse_pkg::FN_OR:   wb.val = a | b;
          mse_pkg::FN_NOR:  wb.val = ~(a | b);
          mse_pkg::FN_SLT:  wb.val = {31'd0, $signed(a) < $signed(b)};
          mse_pkg::FN_SLTU: wb.val = {31'd0, a < b};
          mse_pkg::FN_SLL:  wb.val = b << w[10:6];
          mse_pkg::FN_SRL:  wb.val = b >> w[10:6];
          default:          wb.we  = 1'b0;
        endcase
      end
      mse_pkg::OP_JAL: begin
        wb.we  = 1'b1;
        wb.idx = 5'd31;
        wb.val = pc + 32'd8;
      end
      mse_pkg::OP_ADDI, mse_pkg::OP_ADDIU: begin
        wb.we = 1'b1; wb.idx = w[20:16]; wb.val = a + simm;
      end
      mse_pkg::OP_SLTI: begin
        wb.we = 1'b1; wb.idx = w[20:16];
        wb.val = {31'd0, $signed(a) < $signed(simm)};
      end
      mse_pkg::OP_SLTIU: begin
        wb.we = 1'b1; wb.idx = w[20:16]; wb.val = {31'd0, a < simm};
      end
      mse_pkg::OP_ANDI: begin
        wb.we = 1'b1; wb.idx = w[20:16]; wb.val = a & zimm;
      end
      mse_pkg::OP_ORI: begin
        wb.we = 1'b1; wb.idx = w[20:16]; wb.val = a | zimm;
      end
      mse_pkg::OP_LUI: begin
        wb.we = 1'b1; wb.idx = w[20:16]; wb.val = {w[15:0], 16'h0000};
      end
      mse_pkg::OP_LW: begin
        wb.we = 1'b1; wb.idx = w[20:16]; wb.val = dword;
      end
      mse_pkg::OP_LBU: begin
        wb.we = 1'b1; wb.idx = w[20:16]; wb.val = {24'd0, byte_sh[7:0]};
      end
      mse_pkg::OP_LHU: begin
        wb.we = 1'b1; wb.idx = w[20:16]; wb.val = {16'd0, half_sh[15:0]};
      end
      default: wb = '0;
    endcase
    // r0 is hardwired
    if (wb.idx == 5'd0) begin
      wb = '0;
    end
  end
endmodule
`default_nettype wire

@@ sv/mips32_subset_execute.sv @@
// channel  | dir | tdata (low bit up)                       | tuser
// s_axis   | in  | instr_word[31:0] load_addr[63:32]        | kind
// m_axis   | out | pc_after halted reg_written reg_index    | -
//          |     | reg_value mem_written mem_addr store_word |
// apb      | in  | 0x0 text_base, 0x4 code_size             | -
// Each item passes through the register file read, then operand/branch
// work plus the data memory read, then writeback into both memories.
// The next item is taken on the writeback edge; a bypass covers that edge.
// After reset a clearing pass zeroes all of data memory; no item is
// accepted during it. DMEM_WORDS must be a power of two; the block does not enforce it.
// The output register holds a result while m_tready is low.
`default_nettype none
`include "mips32_subset_execute_macros.svh"
module mips32_subset_execute #(
  parameter int unsigned DMEM_WORDS = mse_pkg::DMEM_WORDS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [63:0]  s_tdata,   // instr_word, load_addr
  input  wire logic         s_tuser,   // kind
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [135:0]      m_tdata,   // pc_after, halted, reg_written, reg_index,
                                       // reg_value, mem_written, mem_addr, store_word
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  localparam int unsigned AW = $clog2(DMEM_WORDS);

  logic [31:0] text_base, code_size, pc;
  logic        clr;
  logic [AW-1:0] clr_idx;
  logic        vb, vc;
  logic        c_go, acc;

  // stage B
  logic        b_kind;
  logic [31:0] b_w, b_laddr;
  logic [31:0] rf_qa, rf_qb;
  logic [31:0] rf [32];
  logic [31:0] rf_valid;
  logic        lastw_v;
  logic [4:0]  lastw_idx;
  logic [31:0] lastw_val;
  logic [4:0]  rs, rt;
  logic [31:0] a, b, simm, ea, pc4, b_next;
  logic        b_halt;

  // stage C
  logic        c_kind, c_halt;
  logic [31:0] c_w, c_a, c_b, c_ea, c_pc, c_next, c_laddr;
  logic [31:0] dm_q;
  logic [31:0] dmem [DMEM_WORDS];
  mse_pkg::wb_t wb;
  logic        rf_we;
  logic [4:0]  rf_widx;
  logic        c_exec, c_store;
  logic        dm_we;
  logic [AW-1:0] dm_waddr;
  logic [31:0] dm_wdata;

  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == mse_pkg::REG_CODE_SIZE) ? code_size : text_base;

  assign c_go     = vc && (!m_tvalid || m_tready);
  assign s_tready = !clr && !vb && (!vc || c_go);
  assign acc      = s_tvalid && s_tready;

  // operand fetch with bypass of the write on the read edge
  assign rs = b_w[25:21];
  assign rt = b_w[20:16];
  always_comb begin
    if (rs == 5'd0) begin
      a = '0;
    end else if (lastw_v && lastw_idx == rs) begin
      a = lastw_val;
    end else begin
      a = rf_valid[rs] ? rf_qa : '0;
    end
    if (rt == 5'd0) begin
      b = '0;
    end else if (lastw_v && lastw_idx == rt) begin
      b = lastw_val;
    end else begin
      b = rf_valid[rt] ? rf_qb : '0;
    end
  end

  assign simm = {{16{b_w[15]}}, b_w[15:0]};
  assign ea   = a + simm;
  assign pc4  = pc + 32'd4;
  assign b_halt = (b_kind == mse_pkg::KIND_EXEC) &&
                  ((pc < text_base) ||
                   ({1'b0, pc} >= ({1'b0, text_base} + {1'b0, code_size})));

  always_comb begin
    if (b_kind == mse_pkg::KIND_PRELOAD || b_halt) begin
      b_next = pc;
    end else begin
      b_next = pc4;
      unique case (b_w[31:26])
        mse_pkg::OP_SPECIAL: if (b_w[5:0] == mse_pkg::FN_JR) b_next = a;
        mse_pkg::OP_J, mse_pkg::OP_JAL: b_next = {pc4[31:28], b_w[25:0], 2'b00};
        mse_pkg::OP_BEQ: if (a == b) b_next = pc4 + {simm[29:0], 2'b00};
        mse_pkg::OP_BNE: if (a != b) b_next = pc4 + {simm[29:0], 2'b00};
        default: b_next = pc4;
      endcase
    end
  end

  mse_alu u_alu (
    .w     (c_w),
    .a     (c_a),
    .b     (c_b),
    .pc    (c_pc),
    .dword (dm_q),
    .ea_lo (c_ea[1:0]),
    .wb    (wb)
  );

  assign c_exec  = (c_kind == mse_pkg::KIND_EXEC) && !c_halt;
  assign c_store = c_exec && (c_w[31:26] == mse_pkg::OP_SW);
  assign rf_we   = c_go && c_exec && wb.we;
  assign rf_widx = wb.idx;

  always_comb begin
    if (clr) begin
      dm_we = 1'b1; dm_waddr = clr_idx; dm_wdata = '0;
    end else if (c_kind == mse_pkg::KIND_PRELOAD) begin
      dm_we = c_go; dm_waddr = c_laddr[AW+1:2]; dm_wdata = c_w;
    end else begin
      dm_we = c_go && c_store; dm_waddr = c_ea[AW+1:2]; dm_wdata = c_b;
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (rf_we) rf[rf_widx] <= wb.val;
    if (acc) begin
      rf_qa <= rf[s_tdata[25:21]];
      rf_qb <= rf[s_tdata[20:16]];
    end
  end

  always_ff @(posedge clk) begin
    if (dm_we) dmem[dm_waddr] <= dm_wdata;
    if (vb) dm_q <= dmem[ea[AW+1:2]];
  end

  // payload
  always_ff @(posedge clk) begin
    lastw_idx <= rf_widx;
    lastw_val <= wb.val;
    if (acc) begin
      b_kind  <= s_tuser;
      b_w     <= s_tdata[31:0];
      b_laddr <= s_tdata[63:32];
    end
    if (vb) begin
      c_kind  <= b_kind;
      c_halt  <= b_halt;
      c_w     <= b_w;
      c_a     <= a;
      c_b     <= b;
      c_ea    <= ea;
      c_pc    <= pc;
      c_next  <= b_next;
      c_laddr <= b_laddr;
    end
    if (c_go) begin
      m_tdata[31:0]    <= c_next;
      m_tdata[32]      <= c_halt && (c_kind == mse_pkg::KIND_EXEC);
      m_tdata[33]      <= c_exec && wb.we;
      m_tdata[38:34]   <= (c_exec && wb.we) ? wb.idx : 5'd0;
      m_tdata[70:39]   <= (c_exec && wb.we) ? wb.val : 32'd0;
      m_tdata[71]      <= c_store;
      m_tdata[103:72]  <= c_store ? c_ea : 32'd0;
      m_tdata[135:104] <= c_store ? c_b : 32'd0;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      text_base <= mse_pkg::TEXT_BASE_RST;
      code_size <= mse_pkg::CODE_SIZE_RST;
      pc        <= mse_pkg::TEXT_BASE_RST;
      clr       <= 1'b1;
      clr_idx   <= '0;
      vb        <= 1'b0;
      vc        <= 1'b0;
      m_tvalid  <= 1'b0;
      rf_valid  <= '0;
      lastw_v   <= 1'b0;
    end else begin
      if (clr) begin
        clr_idx <= clr_idx + 1'b1;
        if (clr_idx == AW'(DMEM_WORDS - 1)) clr <= 1'b0;
      end
      vb <= acc;
      if (vb) begin
        vc <= 1'b1;
        pc <= b_next;
      end else if (c_go) begin
        vc <= 1'b0;
      end
      if (c_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      lastw_v <= rf_we;
      if (rf_we) rf_valid[rf_widx] <= 1'b1;
      if (cfg_we) begin
        if (paddr[2] == mse_pkg::REG_TEXT_BASE) begin
          text_base <= pwdata;
          pc        <= pwdata;
        end else begin
          code_size <= pwdata;
        end
      end
    end
  end

  `MSE_ASSERT_IMP(a_no_accept_in_clear, clr, !s_tready)
  `MSE_ASSERT_NXT(a_b_moves_to_c, vb, vc)
  `MSE_ASSERT_IMP(a_one_in_flight, vb, !vc)
  `MSE_ASSERT_IMP(a_no_r0_write, rf_we, rf_widx != 5'd0)
endmodule
`default_nettype wire

@@ dv/mips32_subset_execute_tb.sv @@
`timescale 1ns / 100ps
`default_nettype none
module mips32_subset_execute_tb;
  import mse_pkg::*;

  localparam int DMEM_WORDS = DMEM_WORDS_DEF;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic        kind;
    logic [31:0] word;
    logic [31:0] addr;
  } item_t;

  typedef struct packed {
    logic [31:0] pc_after;
    logic        halted;
    logic        reg_written;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic        mem_written;
    logic [31:0] mem_addr;
    logic [31:0] store_word;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [63:0] s_tdata = '0;   // instr_word, load_addr
  logic s_tuser = 1'b0;        // kind
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [135:0] m_tdata;       // pc_after, halted, reg_written, reg_index,
                               // reg_value, mem_written, mem_addr, store_word
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  mips32_subset_execute u_dut (.*);

  always #5 clk = ~clk;

  // core model state
  logic [31:0] text_base, code_size, pc;
  logic [31:0] regs [32];
  logic [31:0] dmem [DMEM_WORDS];

  item_t   pending_items[$];
  result_t expected_results[$];
  int errors = 0;
  int idle_cycles = 0;
  bit hold_off = 1'b0;
  int hold_cnt = 0;
  bit stall_burst = 1'b0;
  bit in_taken = 1'b0;

  function automatic logic [31:0] sext16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic int unsigned widx(logic [31:0] a);
    return (a >> 2) % DMEM_WORDS;
  endfunction

  function automatic result_t execute_item(item_t it);
    result_t r;
    logic [31:0] nxt, a, b, simm, ea, mw;
    logic [5:0] op, fn;
    logic [4:0] rt, rd;
    r = '0;
    nxt = pc + 4;
    if (it.kind == KIND_PRELOAD) begin
      dmem[widx(it.addr)] = it.word;
      r.pc_after = pc;
      return r;
    end
    if (pc < text_base || {1'b0, pc} >= {1'b0, text_base} + {1'b0, code_size}) begin
      r.pc_after = pc;
      r.halted = 1'b1;
      return r;
    end
    op = it.word[31:26];
    rt = it.word[20:16];
    rd = it.word[15:11];
    fn = it.word[5:0];
    a = regs[it.word[25:21]];
    b = regs[rt];
    simm = sext16(it.word[15:0]);
    ea = a + simm;
    mw = dmem[widx(ea)];
    if (op == OP_SPECIAL) begin
      r.reg_written = 1'b1;
      r.reg_index = rd;
      case (fn)
        FN_ADD, FN_ADDU: r.reg_value = a + b;
        FN_SUB, FN_SUBU: r.reg_value = a - b;
        FN_AND: r.reg_value = a & b;
        FN_OR:  r.reg_value = a | b;
        FN_NOR: r.reg_value = ~(a | b);
        FN_SLT: r.reg_value = ($signed(a) < $signed(b)) ? 1 : 0;
        FN_SLTU: r.reg_value = (a < b) ? 1 : 0;
        FN_SLL: r.reg_value = b << it.word[10:6];
        FN_SRL: r.reg_value = b >> it.word[10:6];
        FN_JR: begin
          r.reg_written = 1'b0;
          nxt = a;
        end
        default: r.reg_written = 1'b0;
      endcase
    end else if (op == OP_J || op == OP_JAL) begin
      if (op == OP_JAL) begin
        r.reg_written = 1'b1;
        r.reg_index = 5'd31;
        r.reg_value = pc + 8;
      end
      nxt = ((pc + 4) & 32'hf000_0000) | ((it.word << 2) & 32'h0fff_ffff);
    end else begin
      r.reg_written = 1'b1;
      r.reg_index = rt;
      case (op)
        OP_BEQ: begin
          r.reg_written = 1'b0;
          if (a == b) nxt = pc + 4 + (simm << 2);
        end
        OP_BNE: begin
          r.reg_written = 1'b0;
          if (a != b) nxt = pc + 4 + (simm << 2);
        end
        OP_ADDI, OP_ADDIU: r.reg_value = a + simm;
        OP_SLTI: r.reg_value = ($signed(a) < $signed(simm)) ? 1 : 0;
        OP_SLTIU: r.reg_value = (a < simm) ? 1 : 0;
        OP_ANDI: r.reg_value = a & {16'h0, it.word[15:0]};
        OP_ORI:  r.reg_value = a | {16'h0, it.word[15:0]};
        OP_LUI:  r.reg_value = {it.word[15:0], 16'h0};
        OP_LW:   r.reg_value = mw;
        OP_LBU:  r.reg_value = (mw >> (ea[1:0] * 8)) & 32'hff;
        OP_LHU:  r.reg_value = (mw >> (ea[1] * 16)) & 32'hffff;
        OP_SW: begin
          r.reg_written = 1'b0;
          r.mem_written = 1'b1;
          r.mem_addr = ea;
          r.store_word = b;
          dmem[widx(ea)] = b;
        end
        default: r.reg_written = 1'b0;
      endcase
    end
    if (r.reg_written && r.reg_index == 0) r.reg_written = 1'b0;
    if (r.reg_written) regs[r.reg_index] = r.reg_value;
    else begin
      r.reg_index = '0;
      r.reg_value = '0;
    end
    pc = nxt;
    r.pc_after = nxt;
    return r;
  endfunction

  // input transfer seen at the rising edge
  always @(posedge clk) begin
    in_taken <= !rst && s_tvalid && s_tready;
  end

  // driver: bursts and gaps
  int gap_left = 0, burst_left = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (in_taken) begin
        expected_results.push_back(execute_item(pending_items.pop_front()));
        burst_left = burst_left - 1;
      end
      if (!s_tvalid || in_taken) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          s_tvalid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
          end
          s_tvalid <= (gap_left == 0);
          s_tdata <= {pending_items[0].addr, pending_items[0].word};
          s_tuser <= pending_items[0].kind;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern; the long hold-off is counted here
  int rx_phase = 0;
  always @(negedge clk) begin
    rx_phase <= rx_phase + 1;
    if (hold_off && hold_cnt < HOLD_CYCLES) begin
      hold_cnt <= hold_cnt + 1;
      m_tready <= 1'b0;
    end
    else if (stall_burst) m_tready <= 1'b1;
    else m_tready <= (rx_phase % 64 < 40) ? ($urandom_range(0, 3) != 0) : 1'b1;
  end

  // monitor
  always @(posedge clk) begin
    result_t got, exp;
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        got = {m_tdata[31:0], m_tdata[32], m_tdata[33], m_tdata[38:34], m_tdata[70:39],
               m_tdata[71], m_tdata[103:72], m_tdata[135:104]};
        if (expected_results.size() == 0) begin
          $error("result with none expected");
          errors++;
        end else begin
          exp = expected_results.pop_front();
          if (got.pc_after !== exp.pc_after) begin
            $error("pc_after exp %h got %h", exp.pc_after, got.pc_after); errors++;
          end
          if (got.halted !== exp.halted) begin
            $error("halted exp %b got %b", exp.halted, got.halted); errors++;
          end
          if (got.reg_written !== exp.reg_written) begin
            $error("reg_written exp %b got %b", exp.reg_written, got.reg_written); errors++;
          end
          if (got.reg_index !== exp.reg_index) begin
            $error("reg_index exp %0d got %0d", exp.reg_index, got.reg_index); errors++;
          end
          if (got.reg_value !== exp.reg_value) begin
            $error("reg_value exp %h got %h", exp.reg_value, got.reg_value); errors++;
          end
          if (got.mem_written !== exp.mem_written) begin
            $error("mem_written exp %b got %b", exp.mem_written, got.mem_written); errors++;
          end
          if (got.mem_addr !== exp.mem_addr) begin
            $error("mem_addr exp %h got %h", exp.mem_addr, got.mem_addr); errors++;
          end
          if (got.store_word !== exp.store_word) begin
            $error("store_word exp %h got %h", exp.store_word, got.store_word); errors++;
          end
        end
      end
    end
  end

  // watchdog; limit leaves room for the clearing pass after reset
  always @(posedge clk) begin
    if (idle_cycles > WATCHDOG_LIMIT + DMEM_WORDS) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= data; penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == {REG_TEXT_BASE, 2'b00}) begin
      text_base = data;
      pc = data;
    end else code_size = data;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic drain;
    while (pending_items.size() > 0 || expected_results.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic item_t mk(logic kind, logic [31:0] word, logic [31:0] addr);
    item_t it;
    it.kind = kind; it.word = word; it.addr = addr;
    return it;
  endfunction

  function automatic logic [31:0] rtype(int unsigned rs, rt, rd, sh, logic [5:0] fn);
    return {OP_SPECIAL, 5'(rs), 5'(rt), 5'(rd), 5'(sh), fn};
  endfunction

  function automatic logic [31:0] itype(logic [5:0] op, int unsigned rs, rt, imm);
    return {op, 5'(rs), 5'(rt), 16'(imm)};
  endfunction

  // mostly legal ops with small register sets so values get reused
  function automatic item_t random_item();
    logic [5:0] ops [17] = '{OP_SPECIAL, OP_SPECIAL, OP_SPECIAL, OP_J, OP_JAL, OP_BEQ,
                            OP_BNE, OP_ADDI, OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ANDI,
                            OP_ORI, OP_LUI, OP_LW, OP_LBU, OP_SW};
    logic [5:0] fns [12] = '{FN_SLL, FN_SRL, FN_JR, FN_ADD, FN_ADDU, FN_SUB, FN_SUBU,
                            FN_AND, FN_OR, FN_NOR, FN_SLT, FN_SLTU};
    logic [5:0] op;
    int unsigned rs, rt, rd;
    int unsigned imm;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 6) return mk(KIND_PRELOAD, $urandom, $urandom);
    if (sel < 11) return mk(KIND_EXEC, $urandom, $urandom);
    rs = $urandom_range(0, 7); rt = $urandom_range(0, 7); rd = $urandom_range(0, 7);
    if ($urandom_range(0, 9) == 0) begin
      rs = $urandom; rt = $urandom; rd = $urandom;
    end
    imm = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 64) - 32;
    op = (sel < 14) ? OP_LHU : ops[$urandom_range(0, 16)];
    if (op == OP_SPECIAL) begin
      sel = $urandom_range(0, 11);
      // jr lands in range only with r0 usually
      if (fns[sel] == FN_JR && $urandom_range(0, 3) != 0) sel = 3;
      return mk(KIND_EXEC, rtype(rs, rt, rd, $urandom, fns[sel]), $urandom);
    end
    if (op == OP_J || op == OP_JAL)
      return mk(KIND_EXEC, {op, 26'((text_base + 4 * $urandom_range(0, 60)) >> 2)},
                $urandom);
    if ((op == OP_BEQ || op == OP_BNE) && $urandom_range(0, 3) != 0)
      imm = $urandom_range(0, 8) - 4;
    return mk(KIND_EXEC, itype(op, rs, rt, imm), $urandom);
  endfunction

  initial begin
    text_base = TEXT_BASE_RST;
    code_size = CODE_SIZE_RST;
    pc = TEXT_BASE_RST;
    foreach (regs[i]) regs[i] = '0;
    foreach (dmem[i]) dmem[i] = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // default code_size 0: halted, but preload still lands
    pending_items.push_back(mk(KIND_EXEC, rtype(1, 2, 3, 0, FN_ADD), 0));
    pending_items.push_back(mk(KIND_PRELOAD, 32'hdead_beef, 32'h0000_0010));
    drain();

    apb_write(3'h4, 32'h0000_0400);
    apb_write(3'h0, 32'h0000_1000);
    pending_items.push_back(mk(KIND_EXEC, itype(OP_LUI, 0, 1, 'h8000), 0));
    pending_items.push_back(mk(KIND_EXEC, itype(OP_ORI, 1, 1, 'hffff), 0));
    pending_items.push_back(mk(KIND_EXEC, itype(OP_ADDIU, 0, 2, 'hffff), 0));
    pending_items.push_back(mk(KIND_EXEC, rtype(1, 2, 3, 0, FN_ADD), 0));
    pending_items.push_back(mk(KIND_EXEC, rtype(1, 2, 4, 0, FN_SLT), 0));
    pending_items.push_back(mk(KIND_EXEC, rtype(1, 2, 5, 0, FN_SLTU), 0));
    pending_items.push_back(mk(KIND_EXEC, itype(OP_SLTI, 1, 6, 'h7fff), 0));
    pending_items.push_back(mk(KIND_EXEC, itype(OP_SLTIU, 2, 6, 'hffff), 0));
    pending_items.push_back(mk(KIND_EXEC, rtype(0, 1, 0, 31, FN_SLL), 0));
    pending_items.push_back(mk(KIND_EXEC, rtype(0, 1, 7, 31, FN_SRL), 0));
    pending_items.push_back(mk(KIND_EXEC, rtype(1, 2, 8, 0, FN_NOR), 0));
    pending_items.push_back(mk(KIND_EXEC, itype(OP_LW, 0, 9, 'h0013), 0));
    pending_items.push_back(mk(KIND_EXEC, itype(OP_LBU, 0, 10, 'h0013), 0));
    pending_items.push_back(mk(KIND_EXEC, itype(OP_LHU, 0, 11, 'h0012), 0));
    pending_items.push_back(mk(KIND_EXEC, itype(OP_SW, 2, 1, 'h0000), 0));
    pending_items.push_back(mk(KIND_EXEC, itype(OP_BEQ, 0, 0, 'h0001), 0));
    pending_items.push_back(mk(KIND_EXEC, itype(OP_BNE, 1, 2, 'hffff), 0));
    pending_items.push_back(mk(KIND_EXEC, {OP_JAL, 26'h400}, 0));
    pending_items.push_back(mk(KIND_EXEC, rtype(31, 0, 0, 0, FN_JR), 0));
    pending_items.push_back(mk(KIND_EXEC, 32'hffff_ffff, 0));
    pending_items.push_back(mk(KIND_EXEC, {OP_J, 26'h3ff_ffff}, 0));
    pending_items.push_back(mk(KIND_EXEC, 32'h0, 0));
    drain();

    // long receiver hold-off while the sender keeps offering
    apb_write(3'h0, 32'h0000_1000);
    hold_off = 1'b1;
    repeat (60) pending_items.push_back(random_item());
    drain();
    hold_off = 1'b0;

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin apb_write(3'h0, 32'h0000_1000); apb_write(3'h4, 32'h0000_0100); end
        1: begin apb_write(3'h0, 32'h0000_0000); apb_write(3'h4, 32'hffff_fffc); end
        2: begin apb_write(3'h0, 32'hffff_fffc); apb_write(3'h4, 32'hffff_fffc); end
        3: begin apb_write(3'h0, 32'h0040_0000); apb_write(3'h4, 32'h0000_0040); end
        4: begin apb_write(3'h0, 32'h1000_0000); apb_write(3'h4, 32'h0000_0000); end
        default: begin apb_write(3'h0, 32'h0000_2000); apb_write(3'h4, 32'h0000_0200); end
      endcase
      stall_burst = (phase == 3);
      repeat (phase == 4 ? 20 : 120) pending_items.push_back(random_item());
      drain();
    end

    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
`default_nettype wire

@@ mips32_subset_execute.f @@
+incdir+sv
sv/mse_pkg.sv
sv/mse_alu.sv
sv/mips32_subset_execute.sv
dv/mips32_subset_execute_tb.sv
